[hdl/lcs_pkg.sv]
// Shared types and constants for the LCS length engine.
`default_nettype none

package lcs_pkg;

	localparam int SYM_W = 8;
	localparam int OUT_W = 9;

	// Codes carried in s_tuser.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Control and symbol that travel with one query symbol down the chain.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [SYM_W-1:0] sym;
	} lcs_tok_t;

endpackage

`default_nettype wire

[hdl/lcs_cell.sv]
// One cell of the systolic chain: one reference position and its row score.
`default_nettype none

module lcs_cell #(
	parameter int SW  = 9,
	parameter int LW  = 9,
	parameter int IDX = 1
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    adv,
	input  wire  [LW-1:0]          ref_len,
	input  wire                    ref_we,
	input  wire  [LW-1:0]          ref_idx,
	input  wire  [lcs_pkg::SYM_W-1:0] ref_sym,
	input  wire  lcs_pkg::lcs_tok_t tok_in,
	input  wire  [SW-1:0]          left_in,
	input  wire  [SW-1:0]          diag_in,
	output lcs_pkg::lcs_tok_t      tok_q,
	output logic [SW-1:0]          left_q,
	output logic [SW-1:0]          diag_q
);
	import lcs_pkg::*;

	localparam logic [LW-1:0] POS = LW'(IDX - 1);

	logic [SYM_W-1:0] ref_q;
	logic [SW-1:0]    score_q;
	logic [SW-1:0]    own;
	logic [SW-1:0]    cell_val;
	logic             in_ref;

	assign in_ref = POS < ref_len;
	assign own    = tok_in.first ? '0 : score_q;

	always_comb begin
		if (!in_ref) begin
			cell_val = left_in;
		end else if (ref_q == tok_in.sym) begin
			cell_val = diag_in + SW'(1);
		end else begin
			cell_val = (left_in > own) ? left_in : own;
		end
	end

	always_ff @(posedge clk) begin
		if (ref_we && ref_idx == POS) begin
			ref_q <= ref_sym;
		end
		if (adv) begin
			if (tok_in.valid) begin
				score_q <= cell_val;
			end
			left_q <= cell_val;
			diag_q <= own;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_in;
		end
	end

endmodule

`default_nettype wire

[hdl/lcs_length_engine_core.sv]
// Top level of the LCS length engine: loader, systolic cell chain, result register.
//
// Channel  Dir  tvalid/tready      Payload
// s_       in   s_tvalid/s_tready  s_tdata symbol, s_tuser func, s_tlast last
// m_       out  m_tvalid/m_tready  m_tdata lcs_length
//
// A query beat enters the chain every cycle while the chain is not held; its result
// passes through every cell of the chain and then through the result register.
// A load beat waits until no query beat is left in the chain.
// Reset clears the handshake, the open flags, the reference length and the chain
// tokens; no clearing pass is needed. The chain holds only when a result reaches
// its tail while the previous result still waits on m_tready.
`default_nettype none

module lcs_length_engine_core #(
	parameter int MAX_REF = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] symbol
	input  wire  [0:0]  s_tuser,   // [0] func
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // [8:0] lcs_length, [15:9] zero
);
	import lcs_pkg::*;

	localparam int SW = $clog2(MAX_REF + 1);
	localparam int LW = $clog2(MAX_REF + 1);

	lcs_tok_t    tok   [MAX_REF+1];
	logic [SW-1:0] left [MAX_REF+1];
	logic [SW-1:0] diag [MAX_REF+1];

	logic          load_open_q;
	logic          query_open_q;
	logic [LW-1:0] ref_len_q;
	logic [LW-1:0] inflight_q;
	logic          out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic          adv;
	logic          fire;
	logic          load_fire;
	logic          query_fire;
	logic          tail_fire;
	logic [LW-1:0] base_len;
	logic          ref_we;

	// Hold the chain only if a new result would overwrite one still waiting.
	assign adv = !(tok[MAX_REF].valid && tok[MAX_REF].last && out_valid_q && !m_tready);

	// Loads wait for the chain to drain so in-flight queries see a stable reference.
	assign s_tready   = adv && (s_tuser[0] == FUNC_QUERY || inflight_q == '0);
	assign fire       = s_tvalid && s_tready;
	assign load_fire  = fire && s_tuser[0] == FUNC_LOAD;
	assign query_fire = fire && s_tuser[0] == FUNC_QUERY;
	assign tail_fire  = adv && tok[MAX_REF].valid;

	// A load beat with no load open starts a fresh reference at position zero.
	assign base_len = load_open_q ? ref_len_q : '0;
	assign ref_we   = load_fire && (base_len < LW'(MAX_REF));

	// Head of the chain: the incoming query beat against an all-zero boundary column.
	always_comb begin
		tok[0].valid = query_fire;
		tok[0].first = !query_open_q;
		tok[0].last  = s_tlast;
		tok[0].sym   = s_tdata;
		left[0]      = '0;
		diag[0]      = '0;
	end

	for (genvar j = 1; j <= MAX_REF; j++) begin : g_cell
		lcs_cell #(
			.SW  (SW),
			.LW  (LW),
			.IDX (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ref_len (ref_len_q),
			.ref_we  (ref_we),
			.ref_idx (base_len),
			.ref_sym (s_tdata),
			.tok_in  (tok[j-1]),
			.left_in (left[j-1]),
			.diag_in (diag[j-1]),
			.tok_q   (tok[j]),
			.left_q  (left[j]),
			.diag_q  (diag[j])
		);
	end

	// Track load and query state, the reference length and beats in the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_open_q  <= 1'b0;
			query_open_q <= 1'b0;
			ref_len_q    <= '0;
			inflight_q   <= '0;
		end else begin
			if (load_fire) begin
				load_open_q  <= !s_tlast;
				query_open_q <= 1'b0;
				ref_len_q    <= base_len + LW'(ref_we);
			end else if (query_fire) begin
				load_open_q  <= 1'b0;
				query_open_q <= !s_tlast;
			end
			if (query_fire && !tail_fire) begin
				inflight_q <= inflight_q + LW'(1);
			end else if (!query_fire && tail_fire) begin
				inflight_q <= inflight_q - LW'(1);
			end
		end
	end

	// Result register: capture the tail score of a last query beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tail_fire && tok[MAX_REF].last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_fire && tok[MAX_REF].last) begin
			out_data_q <= OUT_W'(left[MAX_REF]);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16-OUT_W){1'b0}}, out_data_q};

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for lcs_length_engine_core with an LCS length tracker.
`timescale 1ns / 1ps

// Tracks the loaded reference and the open DP row and queues the LCS lengths to expect.
class lcs_length_tracker #(int DEPTH = 256);
	logic [7:0] ref_syms[DEPTH];
	int         ref_len;
	int         score_row[DEPTH+1];
	bit         load_open;
	bit         query_open;
	logic [8:0] pending_lengths[$];
	int         fails;
	int         counted;   // beats that change state; overflow loads excluded

	function new();
		ref_len    = 0;
		load_open  = 0;
		query_open = 0;
		fails      = 0;
		counted    = 0;
		foreach (score_row[j])
			score_row[j] = 0;
	endfunction

	function void note_beat(logic func, logic [7:0] sym, logic last);
		int diag;
		int up;
		int cur;
		if (func == lcs_pkg::FUNC_LOAD) begin
			query_open = 0;
			// a load after a closed reference starts a fresh one
			if (!load_open) begin
				ref_len   = 0;
				load_open = 1;
			end
			if (ref_len < DEPTH) begin
				ref_syms[ref_len] = sym;
				ref_len++;
				counted++;
			end
			if (last)
				load_open = 0;
		end else begin
			counted++;
			load_open = 0;
			if (!query_open) begin
				foreach (score_row[j])
					score_row[j] = 0;
				query_open = 1;
			end
			diag = score_row[0];
			for (int j = 1; j <= ref_len; j++) begin
				up = score_row[j];
				if (ref_syms[j-1] == sym)
					cur = diag + 1;
				else
					cur = (score_row[j-1] > up) ? score_row[j-1] : up;
				diag = up;
				score_row[j] = cur;
			end
			if (last) begin
				query_open = 0;
				pending_lengths.push_back(9'(score_row[ref_len]));
			end
		end
	endfunction

	function void check_length(logic [8:0] got);
		logic [8:0] want;
		if (pending_lengths.size() == 0) begin
			$error("lcs_length: unexpected beat, actual %0d", got);
			fails++;
		end else begin
			want = pending_lengths.pop_front();
			if (got !== want) begin
				$error("lcs_length mismatch: expected %0d, actual %0d", want, got);
				fails++;
			end
		end
	endfunction

	function int outstanding();
		return pending_lengths.size();
	endfunction
endclass

module tb;
	import lcs_pkg::*;

	localparam int MAX_REF     = 256;
	localparam int TARGET_BEATS = 1500;
	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 900;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	lcs_length_tracker #(MAX_REF) tracker;

	int         burst_left;
	bit         gaps_on;
	bit         hold_req;
	int         idle_cycles;
	logic [7:0] ref_copy[$];
	int         sym_base;
	int         sym_span;

	lcs_length_engine_core #(.MAX_REF(MAX_REF)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watch both channels at the rising edge; bail out if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_beat(s_tuser[0], s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				tracker.check_length(m_tdata[8:0]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("lcs_length_engine_core verification failed");
				$finish;
			end
		end
	end

	// Result side: random ready stretches, plus one long hold-off on request.
	initial begin
		int hold_left;
		int stretch;
		int ready_pct;
		hold_left = 0;
		stretch   = 0;
		ready_pct = 100;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(50, 300);
					case ($urandom_range(0, 3))
						0: ready_pct = 100;
						1: ready_pct = 70;
						2: ready_pct = 25;
						default: ready_pct = 90;
					endcase
				end
				stretch--;
				m_tready = ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	// Enter and leave at a falling edge; valid stays high across back-to-back beats.
	task automatic send_beat(input logic func, input logic [7:0] sym, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tuser  = func;
		s_tdata  = sym;
		s_tlast  = last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every queued length has come back.
	task automatic drain();
		s_tvalid = 1'b0;
		while (tracker.outstanding() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_sym();
		if (sym_span == 0)
			return 8'($urandom_range(0, 255));
		return 8'(sym_base + $urandom_range(0, sym_span - 1));
	endfunction

	function automatic void pick_alphabet();
		case ($urandom_range(0, 3))
			0: sym_span = 0;
			1: sym_span = 2;
			2: sym_span = 4;
			default: sym_span = 8;
		endcase
		sym_base = $urandom_range(0, 256 - ((sym_span == 0) ? 1 : sym_span));
	endfunction

	task automatic send_reference(input int len, input bit close);
		logic [7:0] sym;
		ref_copy.delete();
		for (int i = 0; i < len; i++) begin
			sym = pick_sym();
			ref_copy.push_back(sym);
			send_beat(FUNC_LOAD, sym, close && (i == len - 1));
		end
	endtask

	// follow_ref mixes in runs of the loaded reference to build long common chains.
	task automatic send_query(input int len, input bit close, input bit follow_ref);
		logic [7:0] sym;
		int         offset;
		offset = $urandom_range(0, 7);
		for (int i = 0; i < len; i++) begin
			if (follow_ref && ref_copy.size() > 0 && $urandom_range(0, 3) != 0)
				sym = ref_copy[(offset + i) % ref_copy.size()];
			else
				sym = pick_sym();
			send_beat(FUNC_QUERY, sym, close && (i == len - 1));
		end
	endtask

	function automatic int pick_ref_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(200, 270);
		return $urandom_range(1, 16);
	endfunction

	function automatic int pick_query_len();
		if ($urandom_range(0, 14) == 0)
			return $urandom_range(40, 90);
		return $urandom_range(1, 12);
	endfunction

	initial begin
		int seq_no;
		int kind;
		tracker     = new();
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		s_tlast     = 1'b0;
		hold_req    = 0;
		idle_cycles = 0;
		burst_left  = 0;
		gaps_on     = 0;
		sym_base    = 0;
		sym_span    = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty reference right after reset: every length is zero.
		send_beat(FUNC_QUERY, 8'h00, 1'b1);
		send_beat(FUNC_QUERY, 8'hFF, 1'b0);
		send_beat(FUNC_QUERY, 8'hFF, 1'b1);
		// Plain load and queries, symbol extremes.
		send_beat(FUNC_LOAD, 8'h00, 1'b0);
		send_beat(FUNC_LOAD, 8'hFF, 1'b0);
		send_beat(FUNC_LOAD, 8'hA5, 1'b1);
		send_beat(FUNC_QUERY, 8'hFF, 1'b0);
		send_beat(FUNC_QUERY, 8'h00, 1'b0);
		send_beat(FUNC_QUERY, 8'hFF, 1'b0);
		send_beat(FUNC_QUERY, 8'hA5, 1'b1);
		send_beat(FUNC_QUERY, 8'hA5, 1'b1);
		send_beat(FUNC_QUERY, 8'h5A, 1'b1);
		// Load aborts an open query; then a query closes the unfinished load.
		send_beat(FUNC_QUERY, 8'h00, 1'b0);
		send_beat(FUNC_LOAD, 8'h5A, 1'b0);
		send_beat(FUNC_LOAD, 8'hC3, 1'b0);
		send_beat(FUNC_QUERY, 8'hC3, 1'b0);
		send_beat(FUNC_QUERY, 8'h5A, 1'b1);
		// A closed load followed by another load replaces the reference.
		send_beat(FUNC_LOAD, 8'h01, 1'b1);
		send_beat(FUNC_LOAD, 8'h80, 1'b1);
		send_beat(FUNC_QUERY, 8'h80, 1'b1);
		send_beat(FUNC_QUERY, 8'h01, 1'b1);
		drain();

		// Full-size reference queried with itself: the largest possible length.
		gaps_on  = 1;
		sym_span = 0;
		send_reference(MAX_REF, 1);
		for (int i = 0; i < MAX_REF; i++)
			send_beat(FUNC_QUERY, ref_copy[i], i == MAX_REF - 1);
		// Overflowing reference: extra symbols are dropped.
		pick_alphabet();
		send_reference(MAX_REF + 9, 1);
		send_query(30, 1, 1);

		seq_no = 0;
		while (tracker.counted < TARGET_BEATS) begin
			seq_no++;
			gaps_on = ($urandom_range(0, 3) != 0);
			pick_alphabet();
			if (seq_no == 6) begin
				// Stall the result side for a long time while short queries keep coming.
				drain();
				hold_req = 1;
				send_reference($urandom_range(2, 10), 1);
				for (int k = 0; k < 30; k++)
					send_query($urandom_range(1, 3), 1, 1);
				drain();
			end else begin
				kind = $urandom_range(0, 99);
				if (kind < 70) begin
					send_reference(pick_ref_len(), 1);
					repeat ($urandom_range(1, 3))
						send_query(pick_query_len(), 1, 1'($urandom_range(0, 1)));
				end else if (kind < 80) begin
					// unterminated load, closed by the query
					send_reference(pick_ref_len(), 0);
					send_query(pick_query_len(), 1, 1);
				end else if (kind < 90) begin
					// query cut short by a new load
					send_query(pick_query_len(), 0, 1);
					send_reference(pick_ref_len(), 1);
					send_query(pick_query_len(), 1, 1);
				end else begin
					repeat ($urandom_range(1, 8))
						send_beat(1'($urandom_range(0, 1)), pick_sym(),
							1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 6) == 0)
					drain();
			end
		end

		drain();
		repeat (MAX_REF + 20) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$error("lcs_length: %0d results never arrived", tracker.outstanding());
			tracker.fails++;
		end
		if (tracker.fails == 0)
			$display("lcs_length_engine_core verification clean");
		else
			$display("lcs_length_engine_core verification failed");
		$finish;
	end
endmodule
